FILE: design/udp_header_rewrite_unit_assert.svh
// assertion macros for the udp header rewrite unit
// expects i_clk and i_rst_n in the including module
`ifndef UDP_HEADER_REWRITE_UNIT_ASSERT_SVH
`define UDP_HEADER_REWRITE_UNIT_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define UHR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// implication from a trigger to a consequence in the next cycle
`define UHR_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/uhr_pkg.sv
// shared types and constants of the udp header rewrite unit
// no dependencies
package uhr_pkg;

    // header store sizing
    localparam int HDR_DEPTH  = 60;
    localparam int HDR_ADDR_W = $clog2(HDR_DEPTH);
    localparam int HDR_CNT_W  = $clog2(HDR_DEPTH + 1);

    // frame layout
    localparam int POS_W        = 7;
    localparam int ETH_LEN      = 14;
    localparam int POS_MAX      = 127;
    localparam int IHL_MIN      = 5;
    localparam int IP_CSUM_HI   = 10;
    localparam int IP_CSUM_LO   = 11;
    localparam int SUM_W        = 21;

    // configuration port
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_MAC    = 3'd0,
        CFG_SOURCE_IP   = 3'd1,
        CFG_DEST_IP     = 3'd2,
        CFG_SOURCE_PORT = 3'd3,
        CFG_DEST_PORT   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_truncated;
    } t_out_item;

endpackage

FILE: design/uhr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module uhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 60,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/udp_header_rewrite_unit.sv
// Ethernet / IPv4 / UDP header rewrite: replaces destination MAC, IP addresses,
// UDP ports, clears the UDP checksum, recomputes the IPv4 header checksum. Uses
// uhr_pkg, uhr_ram and the assertion macro header.
//
// Usage:
//  - input channel i_in_valid / o_in_stall / i_in_data carries one frame byte per
//    transfer; output channel o_out_valid / i_out_stall / o_out_data the same.
//  - configuration is written through i_cfg_wr_en / i_cfg_idx / i_cfg_wdata while
//    the unit is idle; indexes above the destination port are ignored.
//  - Ethernet header and bytes after the IP header: one byte per cycle unless the
//    receiver stalls; the result reaches the output register in the cycle after the transfer.
//  - IP header bytes are written into the header store and produce nothing until
//    the last header byte (or frame end); then the held bytes are read back, one
//    per cycle unless the receiver stalls, through the store's read port and the
//    output register, so a header of N bytes gives a burst of N output bytes.
//    Input is stalled while the burst drains.
//  - a frame ending inside the IP header flushes the held bytes with the
//    truncated flag set.
//  - synchronous reset clears the frame state and configuration; the header
//    store is not cleared, only written entries are ever read.
//  - when the receiver stalls, the output register holds its byte and the input
//    side stalls as soon as a new byte would need the output register.
`include "udp_header_rewrite_unit_assert.svh"

module udp_header_rewrite_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [uhr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [uhr_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  uhr_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output uhr_pkg::t_out_item                  o_out_data
);

    import uhr_pkg::*;

    typedef enum logic [1:0] {
        S_PASS  = 2'b01,
        S_FLUSH = 2'b10
    } t_state;

    // ones' complement fold of the running header sum
    function automatic logic [15:0] fold_sum(input logic [SUM_W-1:0] s);
        logic [16:0] s1;
        logic [16:0] s2;
        s1 = {1'b0, s[15:0]} + 17'(s[SUM_W-1:16]);
        s2 = s1 + 17'(s1[16]);
        return ~s2[15:0];
    endfunction

    // configuration registers
    logic [47:0] r_dest_mac;
    logic [31:0] r_source_ip;
    logic [31:0] r_dest_ip;
    logic [15:0] r_source_port;
    logic [15:0] r_dest_port;

    // frame state
    t_state               r_state;
    logic [POS_W-1:0]     r_byte_pos;
    logic [3:0]           r_header_words;
    logic [SUM_W-1:0]     r_sum;
    logic [15:0]          r_csum;
    logic [HDR_CNT_W-1:0] r_flush_count;
    logic                 r_flush_last;
    logic                 r_flush_trunc;
    logic [HDR_CNT_W-1:0] r_issue_idx;
    logic                 r_rd_valid;
    logic [HDR_CNT_W-1:0] r_rd_idx;

    // output register
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic [POS_W-1:0]     off;
    logic [POS_W-1:0]     hlen;
    logic [POS_W-1:0]     hlen_raw;
    logic                 in_eth;
    logic                 in_hdr;
    logic                 hdr_done;
    logic                 flush_go;
    logic                 out_ready;
    logic                 in_acc;
    logic                 issue;
    logic                 flush_load;
    logic                 pass_load;
    logic [7:0]           hdr_byte;
    logic [7:0]           pass_byte;
    logic [2:0]           mac_sel;
    logic [POS_W-1:0]     udp_off;
    logic [SUM_W-1:0]     addend;
    logic [SUM_W-1:0]     sum_next;
    logic [7:0]           rd_data;
    logic [7:0]           flush_byte;
    logic [3:0]           ihl;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_mac    <= '0;
            r_source_ip   <= '0;
            r_dest_ip     <= '0;
            r_source_port <= '0;
            r_dest_port   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_DEST_MAC:    r_dest_mac    <= i_cfg_wdata;
                CFG_SOURCE_IP:   r_source_ip   <= i_cfg_wdata[31:0];
                CFG_DEST_IP:     r_dest_ip     <= i_cfg_wdata[31:0];
                CFG_SOURCE_PORT: r_source_port <= i_cfg_wdata[15:0];
                CFG_DEST_PORT:   r_dest_port   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // position decode
    assign off      = r_byte_pos - POS_W'(ETH_LEN);
    assign hlen_raw = {1'b0, r_header_words, 2'b00};
    assign hlen     = (hlen_raw > POS_W'(HDR_DEPTH)) ? POS_W'(HDR_DEPTH) : hlen_raw;
    assign in_eth   = r_byte_pos < POS_W'(ETH_LEN);
    assign in_hdr   = !in_eth && ((off == '0) || (off < hlen));
    assign hdr_done = in_hdr && (off == hlen - POS_W'(1));
    assign flush_go = in_hdr && (hdr_done || i_in_data.in_last);

    // handshake
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_PASS) || (!in_hdr && !out_ready);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign pass_load  = in_acc && !in_hdr;

    // rewritten header byte
    always_comb begin
        hdr_byte = i_in_data.in_byte;
        case (off)
            7'd10, 7'd11: hdr_byte = 8'h00;
            7'd12: hdr_byte = r_source_ip[31:24];
            7'd13: hdr_byte = r_source_ip[23:16];
            7'd14: hdr_byte = r_source_ip[15:8];
            7'd15: hdr_byte = r_source_ip[7:0];
            7'd16: hdr_byte = r_dest_ip[31:24];
            7'd17: hdr_byte = r_dest_ip[23:16];
            7'd18: hdr_byte = r_dest_ip[15:8];
            7'd19: hdr_byte = r_dest_ip[7:0];
            default: ;
        endcase
    end

    // checksum accumulation, even offsets are the high byte
    assign addend   = off[0] ? SUM_W'(hdr_byte) : SUM_W'({hdr_byte, 8'h00});
    assign sum_next = r_sum + addend;
    assign ihl      = i_in_data.in_byte[3:0];

    // pass-through byte: mac, ethernet tail, udp header and payload
    assign mac_sel = 3'd5 - r_byte_pos[2:0];
    assign udp_off = off - hlen;
    always_comb begin
        pass_byte = i_in_data.in_byte;
        if (in_eth) begin
            if (r_byte_pos < POS_W'(6)) begin
                pass_byte = r_dest_mac[{mac_sel, 3'b000} +: 8];
            end
        end else begin
            case (udp_off)
                7'd0: pass_byte = r_source_port[15:8];
                7'd1: pass_byte = r_source_port[7:0];
                7'd2: pass_byte = r_dest_port[15:8];
                7'd3: pass_byte = r_dest_port[7:0];
                7'd6, 7'd7: pass_byte = 8'h00;
                default: ;
            endcase
        end
    end

    // frame position, header length and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos     <= '0;
            r_header_words <= 4'(IHL_MIN);
            r_sum          <= '0;
        end else if (in_acc) begin
            if (i_in_data.in_last) begin
                r_byte_pos     <= '0;
                r_header_words <= 4'(IHL_MIN);
                r_sum          <= '0;
            end else begin
                if (r_byte_pos < POS_W'(POS_MAX)) begin
                    r_byte_pos <= r_byte_pos + POS_W'(1);
                end
                if (in_hdr) begin
                    r_sum <= sum_next;
                end
                if (in_hdr && (off == '0)) begin
                    r_header_words <= (ihl < 4'(IHL_MIN)) ? 4'(IHL_MIN) : ihl;
                end
            end
        end
    end

    // header store
    uhr_ram #(
        .WIDTH (8),
        .DEPTH (HDR_DEPTH)
    ) u_hdr_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && in_hdr),
        .i_wr_addr (off[HDR_ADDR_W-1:0]),
        .i_wr_data (hdr_byte),
        .i_rd_en   (issue),
        .i_rd_addr (r_issue_idx[HDR_ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    // flush read-out: issue a read when the read stage can move on
    assign issue      = (r_state == S_FLUSH) && (r_issue_idx != r_flush_count)
                        && (!r_rd_valid || out_ready);
    assign flush_load = r_rd_valid && out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_PASS;
            r_rd_valid    <= 1'b0;
            r_issue_idx   <= '0;
            r_flush_count <= '0;
            r_flush_last  <= 1'b0;
            r_flush_trunc <= 1'b0;
        end else begin
            unique case (r_state)
                S_PASS: begin
                    if (in_acc && flush_go) begin
                        r_state       <= S_FLUSH;
                        r_issue_idx   <= '0;
                        r_flush_count <= off[HDR_CNT_W-1:0] + HDR_CNT_W'(1);
                        r_flush_last  <= i_in_data.in_last;
                        r_flush_trunc <= !hdr_done;
                    end
                end
                S_FLUSH: begin
                    if (issue) begin
                        r_issue_idx <= r_issue_idx + HDR_CNT_W'(1);
                        r_rd_valid  <= 1'b1;
                    end else if (flush_load) begin
                        r_rd_valid <= 1'b0;
                    end
                    if ((r_issue_idx == r_flush_count) && !r_rd_valid) begin
                        r_state <= S_PASS;
                    end
                end
                default: r_state <= S_PASS;
            endcase
        end
    end

    // payload of the flush path
    always_ff @(posedge i_clk) begin
        if (in_acc && flush_go) begin
            r_csum <= fold_sum(sum_next);
        end
        if (issue) begin
            r_rd_idx <= r_issue_idx;
        end
    end

    always_comb begin
        flush_byte = rd_data;
        if (r_rd_idx == HDR_CNT_W'(IP_CSUM_HI)) begin
            flush_byte = r_csum[15:8];
        end else if (r_rd_idx == HDR_CNT_W'(IP_CSUM_LO)) begin
            flush_byte = r_csum[7:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pass_load || flush_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pass_load) begin
            r_out_data.out_byte      <= pass_byte;
            r_out_data.out_last      <= i_in_data.in_last;
            r_out_data.out_truncated <= in_eth && i_in_data.in_last;
        end else if (flush_load) begin
            r_out_data.out_byte      <= flush_byte;
            r_out_data.out_last      <= r_flush_last
                                        && (r_rd_idx == r_flush_count - HDR_CNT_W'(1));
            r_out_data.out_truncated <= r_flush_trunc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    `UHR_ASSERT(a_rd_only_in_flush, !r_rd_valid || (r_state == S_FLUSH), "read stage busy outside flush")
    `UHR_ASSERT(a_issue_bound, (r_state != S_FLUSH) || (r_issue_idx <= r_flush_count), "read index past held bytes")
    `UHR_ASSERT(a_flush_nonempty, (r_state != S_FLUSH) || (r_flush_count != '0), "flush with no held bytes")
    `UHR_ASSERT_NEXT(a_flush_start, in_acc && flush_go, (r_state == S_FLUSH) && (r_issue_idx == '0), "header end did not start flush")

endmodule
